### rtl/core/iir_df2_pkg.sv
// Shared types and constants for the direct form II IIR filter.
// No dependencies.
`timescale 1ns / 1ps
package iir_df2_pkg;
  localparam logic [2:0] FUNC_SAMPLE  = 3'd0;
  localparam logic [2:0] FUNC_NUM     = 3'd1;
  localparam logic [2:0] FUNC_DEN     = 3'd2;
  localparam logic [2:0] FUNC_INIT    = 3'd3;
  localparam logic [2:0] FUNC_RESTORE = 3'd4;

  localparam logic [0:0] REG_ORDER = 1'd0;
  localparam logic [0:0] REG_POST  = 1'd1;

  localparam int unsigned COEF_BITS = 32;
  localparam int unsigned ACC_BITS  = 64;
  localparam int unsigned FRAC_BITS = 27;

  // Handshake between the sequencer and the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic sub;
  } mac_cmd_t;
endpackage

### rtl/core/iir_df2_mac.sv
// Bit-serial 32x32 signed multiply with saturating 64-bit accumulate.
// Depends on iir_df2_pkg.
`timescale 1ns / 1ps
module iir_df2_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iir_df2_pkg::mac_cmd_t cmd_i,
  input  logic signed [31:0]    coef_i,
  input  logic signed [31:0]    data_i,
  input  logic signed [63:0]    acc_i,
  output logic signed [63:0]    acc_o,
  output logic                  done_o
);
  import iir_df2_pkg::*;

  logic [5:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q;
  logic               sub_q, sub_d;
  logic [31:0]        mplr_q, mplr_d;
  logic signed [63:0] mcand_q, mcand_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [63:0] term;
  logic signed [64:0] sum;
  logic               fin;

  // One multiplier bit per cycle; the top bit carries negative weight.
  always_comb begin
    busy_d = busy_q; cnt_d = cnt_q; sub_d = sub_q;
    mplr_d = mplr_q; mcand_d = mcand_q; prod_d = prod_q; acc_d = acc_q;
    term = '0; sum = '0; fin = 1'b0;
    if (cmd_i.start) begin
      busy_d = 1'b1; cnt_d = '0; sub_d = cmd_i.sub;
      mplr_d = coef_i; mcand_d = 64'(data_i); prod_d = '0; acc_d = acc_i;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        term = sub_q ? -prod_q : prod_q;
        sum  = 65'(acc_q) + 65'(term);
        if (sum[64] != sum[63]) acc_d = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else acc_d = sum[63:0];
        busy_d = 1'b0; fin = 1'b1;
      end else begin
        if (mplr_q[0]) prod_d = (cnt_q == 6'd31) ? prod_q - mcand_q : prod_q + mcand_q;
        mcand_d = mcand_q <<< 1;
        mplr_d  = mplr_q >> 1;
        cnt_d   = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; done_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    sub_q <= sub_d; mplr_q <= mplr_d; mcand_q <= mcand_d;
    prod_q <= prod_d; acc_q <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;
endmodule

### rtl/core/iir_direct_form_two_filter_top.sv
// Top level of the direct form II IIR filter: sequencer, tap storage, rounding.
// Depends on iir_df2_pkg and iir_df2_mac.
//
// Channel | Dir | Handshake              | Payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata, tuser (func)
// m_axis  | out | m_axis_tvalid/tready   | tdata, tuser (is_sample, saturated)
// cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample beat of order N runs 2N+1 products through the one bit-serial
// multiply-accumulate unit. Reset clears coefficients, delays and initial
// values. A stalled output holds the result and blocks the next beat.
`timescale 1ns / 1ps
module iir_direct_form_two_filter_top #(
  parameter int unsigned MAX_ORDER   = 8,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: sample_in, batch_end, tap_index[3:0], coef_value[31:0], init_value[31:0]
  input  logic [((SAMPLE_BITS + 69 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: func[2:0]
  input  logic [2:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: sample_out
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: is_sample, saturated
  output logic [1:0] m_axis_tuser,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [3:0] cfg_data_i
);
  import iir_df2_pkg::*;

  localparam int unsigned DEPTH = MAX_ORDER + 1;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW    = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MAC  = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_HEAD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0] st_q, st_d;
  logic [3:0] order_q;
  logic       post_q;
  logic signed [31:0] num_q [DEPTH];
  logic signed [31:0] den_q [DEPTH];
  logic signed [31:0] dly_q [DEPTH];
  logic signed [31:0] ic_q  [DEPTH];

  logic signed [SAMPLE_BITS-1:0] s_sample;
  logic        s_end;
  logic [3:0]  s_idx;
  logic signed [31:0] s_coef, s_init;
  assign s_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_end    = s_axis_tdata[SAMPLE_BITS];
  assign s_idx    = s_axis_tdata[SAMPLE_BITS+4:SAMPLE_BITS+1];
  assign s_coef   = s_axis_tdata[SAMPLE_BITS+36:SAMPLE_BITS+5];
  assign s_init   = s_axis_tdata[SAMPLE_BITS+68:SAMPLE_BITS+37];

  logic [IW:0] n_eff;
  assign n_eff = (32'(order_q) > MAX_ORDER) ? (IW+1)'(MAX_ORDER) : (IW+1)'(order_q);

  logic        in_acc;
  assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Sequencer: j walks taps 1..N, phase picks head (a) or output (b) term.
  logic [IW:0] j_q, j_d;
  logic        ph_q, ph_d;
  logic        end_q, end_d;
  logic signed [63:0] hacc_q, hacc_d, yacc_q, yacc_d;
  logic        sat_q, sat_d;
  logic        ov_q, ov_d;
  logic [SAMPLE_BITS-1:0] y_q, y_d;
  logic        is_s_q, is_s_d;

  mac_cmd_t           cmd;
  logic signed [31:0] m_coef, m_data;
  logic signed [63:0] m_acc, m_res;
  logic               m_done;

  iir_df2_mac u_mac (
    .clk_i, .rst_ni, .cmd_i(cmd), .coef_i(m_coef), .data_i(m_data),
    .acc_i(m_acc), .acc_o(m_res), .done_o(m_done)
  );

  function automatic logic signed [63:0] rnd(input logic signed [63:0] a);
    logic signed [64:0] s;
    logic signed [63:0] t;
    s = 65'(a) + 65'(64'sd1 <<< 26);
    t = (s[64] != s[63]) ? {1'b0, {63{1'b1}}} : s[63:0];
    return t >>> FRAC_BITS;
  endfunction

  logic signed [63:0] r_h, r_y;
  logic signed [31:0] head;
  logic               h_clip, y_clip;
  localparam logic signed [63:0] YMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  assign r_h    = rnd(hacc_q);
  assign r_y    = rnd(yacc_q);
  assign h_clip = (r_h > 64'sh7fffffff) || (r_h < -64'sh80000000);
  assign head   = (r_h > 64'sh7fffffff) ? 32'sh7fffffff :
                  (r_h < -64'sh80000000) ? -32'sh80000000 : r_h[31:0];
  assign y_clip = (r_y > YMAX) || (r_y < -YMAX - 64'sd1);

  always_comb begin
    st_d = st_q; j_d = j_q; ph_d = ph_q; end_d = end_q;
    hacc_d = hacc_q; yacc_d = yacc_q; sat_d = sat_q; ov_d = ov_q;
    y_d = y_q; is_s_d = is_s_q;
    cmd = '0;
    m_coef = ph_q ? num_q[j_q[IW-1:0]] : den_q[j_q[IW-1:0]];
    m_data = dly_q[j_q[IW-1:0]];
    m_acc  = ph_q ? yacc_q : hacc_q;
    cmd.sub = !ph_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          end_d = s_end;
          if (s_axis_tuser == FUNC_SAMPLE) begin
            hacc_d = 64'(s_sample) <<< FRAC_BITS;
            yacc_d = '0; sat_d = 1'b0; j_d = (IW+1)'(1); ph_d = 1'b0;
            st_d = (n_eff == '0) ? ST_HEAD : ST_MAC;
          end else begin
            y_d = '0; is_s_d = 1'b0; ov_d = 1'b1; st_d = ST_DONE;
          end
        end
      end
      ST_MAC: begin
        cmd.start = 1'b1; st_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (m_done) begin
          if (ph_q) yacc_d = m_res; else hacc_d = m_res;
          if (ph_q && j_q == (IW+1)'(0)) begin
            st_d = ST_OUT;
          end else if (ph_q && j_q == n_eff) begin
            st_d = ST_HEAD;
          end else begin
            if (ph_q) j_d = j_q + (IW+1)'(1);
            ph_d = !ph_q;
            st_d = ST_MAC;
          end
        end
      end
      ST_HEAD: begin
        // Head is written into tap 0; the b0 product follows from it.
        sat_d = h_clip; j_d = '0; ph_d = 1'b1; st_d = ST_MAC;
      end
      ST_OUT: begin
        sat_d = sat_q | y_clip;
        y_d = (r_y > YMAX) ? YMAX[SAMPLE_BITS-1:0] :
              (r_y < -YMAX - 64'sd1) ? ~YMAX[SAMPLE_BITS-1:0] : r_y[SAMPLE_BITS-1:0];
        is_s_d = 1'b1; ov_d = 1'b1; st_d = ST_DONE;
      end
      ST_DONE: begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (ov_q && m_axis_tready) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ov_q <= 1'b0; order_q <= '0; post_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        num_q[i] <= '0; den_q[i] <= '0; dly_q[i] <= '0; ic_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; ov_q <= ov_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_ORDER) order_q <= cfg_data_i;
        else post_q <= cfg_data_i[0];
      end
      if (in_acc) begin
        unique case (s_axis_tuser)
          FUNC_NUM: if (32'(s_idx) <= MAX_ORDER) num_q[IW'(s_idx)] <= s_coef;
          FUNC_DEN: if (32'(s_idx) <= MAX_ORDER) den_q[IW'(s_idx)] <= s_coef;
          FUNC_INIT: if (32'(s_idx) < MAX_ORDER) ic_q[IW'(s_idx)] <= s_init;
          FUNC_RESTORE: begin
            for (int i = 0; i < DEPTH; i++)
              dly_q[i] <= ((IW+1)'(i) < n_eff) ? ic_q[i] : '0;
          end
          FUNC_SAMPLE: begin
            for (int i = 1; i < DEPTH; i++)
              if ((IW+1)'(i) <= n_eff) dly_q[i] <= dly_q[i-1];
          end
          default: ;
        endcase
      end
      if (st_q == ST_HEAD) dly_q[0] <= head;
      if (st_q == ST_OUT && post_q && end_q)
        for (int i = 0; i < DEPTH; i++) dly_q[i] <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q <= j_d; ph_q <= ph_d; end_q <= end_d; hacc_q <= hacc_d;
    yacc_q <= yacc_d; sat_q <= sat_d; y_q <= y_d; is_s_q <= is_s_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OW'(y_q);
  assign m_axis_tuser  = {is_s_q & sat_q, is_s_q};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready) else $error("beat taken while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_mac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (st_q == ST_MAC)) else $error("stray multiply start");
`endif
endmodule

### sim/tb_iir_direct_form_two_filter_top.sv
// Self-checking testbench for the direct form II IIR filter top level.
// Depends on iir_df2_pkg and the filter RTL; runs a directed part, random phases and a stall.
`timescale 1ns / 1ps
module tb_iir_direct_form_two_filter_top;
  import iir_df2_pkg::*;

  localparam int unsigned MAX_ORD = 8;
  localparam int unsigned SBITS = 24;
  localparam logic [2:0] FUNC_UNUSED_MIN = 3'd5;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint Q27_ONE = 64'sd1 <<< FRAC_BITS;

  typedef struct packed {
    logic [SBITS-1:0] y;
    logic             is_smp;
    logic             sat;
  } filt_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [3:0] cfg_data_i = '0;

  iir_direct_form_two_filter_top dut (.*);

  always #6 clk_i = ~clk_i;

  // Filter state as the block should hold it.
  longint b_coef[0:MAX_ORD];
  longint a_coef[0:MAX_ORD];
  longint delays[0:MAX_ORD];
  longint init_vals[0:MAX_ORD-1];
  int unsigned order_reg = 0;
  bit post_reg = 0;

  filt_res_t pending[$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_seen = 0;
  int sat_seen = 0;
  int s_idle_pct = 0;
  int r_stall_pct = 0;
  bit hold_rx = 0;
  longint cycles = 0;
  bit out_fire = 0;
  logic [23:0] out_data;
  logic [1:0] out_user;

  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) + $signed({b[63], b});
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic longint clip_to(longint v, int bits, inout bit flag);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    if (v > hi) begin
      flag = 1;
      return hi;
    end
    if (v < -hi - 1) begin
      flag = 1;
      return -hi - 1;
    end
    return v;
  endfunction

  // Applies one accepted beat to the filter state and returns the expected result.
  function automatic filt_res_t filter_beat(logic [2:0] f, logic [23:0] smp, logic be,
                                            logic [3:0] idx, logic [31:0] coef,
                                            logic [31:0] ival);
    filt_res_t r;
    int unsigned n;
    longint h, acc;
    bit sat;
    r = '0;
    sat = 0;
    n = (order_reg > MAX_ORD) ? MAX_ORD : order_reg;
    case (f)
      FUNC_NUM: if (idx <= MAX_ORD) b_coef[idx] = longint'($signed(coef));
      FUNC_DEN: if (idx <= MAX_ORD) a_coef[idx] = longint'($signed(coef));
      FUNC_INIT: if (idx < MAX_ORD) init_vals[idx] = longint'($signed(ival));
      FUNC_RESTORE: for (int j = 0; j <= MAX_ORD; j++) delays[j] = (j < n) ? init_vals[j] : 0;
      FUNC_SAMPLE: begin
        for (int j = n; j >= 1; j--) delays[j] = delays[j-1];
        h = longint'($signed(smp)) * Q27_ONE;
        acc = 0;
        for (int j = 1; j <= n; j++) begin
          h = add_sat(h, -(a_coef[j] * delays[j]));
          acc = add_sat(acc, b_coef[j] * delays[j]);
        end
        delays[0] = clip_to(add_sat(h, 64'sd1 <<< 26) >>> FRAC_BITS, 32, sat);
        acc = add_sat(acc, b_coef[0] * delays[0]);
        acc = clip_to(add_sat(acc, 64'sd1 <<< 26) >>> FRAC_BITS, SBITS, sat);
        if (post_reg && be) for (int j = 0; j <= MAX_ORD; j++) delays[j] = 0;
        r.y = acc[SBITS-1:0];
        r.is_smp = 1;
        r.sat = sat;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [2:0] f, logic [23:0] smp, logic be, logic [3:0] idx,
                           logic [31:0] coef, logic [31:0] ival);
    if (s_idle_pct > 0 && $urandom_range(99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {3'b000, ival, coef, idx, be, smp};
    // Ready only moves at rising edges, so the value seen at the falling edge holds.
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    pending.push_back(filter_beat(f, smp, be, idx, coef, ival));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [3:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (index == REG_ORDER) order_reg = value;
    else post_reg = value[0];
  endtask

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(9))
      0: return $urandom();
      1, 2: return 32'($signed($urandom_range(0, 1 << 28)) - (1 << 27));
      default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
    endcase
  endfunction

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3: return 24'($urandom());
      default: return 24'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_random();
    int k;
    k = $urandom_range(99);
    if (k < 70)
      send_item(FUNC_SAMPLE, rand_sample(), $urandom_range(9) == 0, 4'($urandom()),
                $urandom(), $urandom());
    else if (k < 80)
      send_item(FUNC_NUM, 24'($urandom()), 1'($urandom()), 4'($urandom_range(0, 10)),
                rand_coef(), $urandom());
    else if (k < 90)
      send_item(FUNC_DEN, 24'($urandom()), 1'($urandom()), 4'($urandom_range(0, 10)),
                rand_coef(), $urandom());
    else if (k < 95)
      send_item(FUNC_INIT, 24'($urandom()), 1'($urandom()), 4'($urandom_range(0, 15)),
                $urandom(),
                ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 200)) - 100));
    else if (k < 98)
      send_item(FUNC_RESTORE, 24'($urandom()), 1'($urandom()), 4'($urandom()), $urandom(),
                $urandom());
    else
      send_item(3'($urandom_range(FUNC_UNUSED_MIN, 7)), 24'($urandom()), 1'($urandom()),
                4'($urandom()), $urandom(), $urandom());
  endtask

  task automatic test_directed();
    write_reg(REG_ORDER, 4'd0);
    write_reg(REG_POST, 4'd0);
    // Order zero: plain gain, including a gain large enough to clip.
    send_item(FUNC_NUM, '0, 1'b0, 4'd0, 32'h0800_0000, '0);
    send_item(FUNC_SAMPLE, 24'h7FFFFF, 1'b0, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'h800000, 1'b0, '0, '0, '0);
    send_item(FUNC_NUM, '0, 1'b0, 4'd0, 32'h7FFF_FFFF, '0);
    send_item(FUNC_SAMPLE, 24'h7FFFFF, 1'b0, '0, '0, '0);
    send_item(FUNC_NUM, '0, 1'b0, 4'd0, 32'h8000_0000, '0);
    send_item(FUNC_SAMPLE, 24'h800000, 1'b1, '0, '0, '0);
    // Out-of-range indexes are acknowledged without effect; unused codes too.
    send_item(FUNC_NUM, '0, 1'b0, 4'd15, 32'hFFFF_FFFF, '0);
    send_item(FUNC_DEN, '0, 1'b0, 4'd9, 32'hFFFF_FFFF, '0);
    send_item(FUNC_INIT, '0, 1'b0, 4'd8, '0, 32'hFFFF_FFFF);
    send_item(3'd7, '1, 1'b1, '1, '1, '1);
    send_item(FUNC_NUM, '0, 1'b0, 4'd0, 32'h0800_0000, '0);
    send_item(FUNC_NUM, '0, 1'b0, 4'd8, 32'h0400_0000, '0);
    send_item(FUNC_DEN, '0, 1'b0, 4'd1, 32'hFC00_0000, '0);
    send_item(FUNC_INIT, '0, 1'b0, 4'd0, '0, 32'h7FFF_FFFF);
    send_item(FUNC_INIT, '0, 1'b0, 4'd7, '0, 32'h8000_0000);
    // An order above the maximum acts as the maximum.
    write_reg(REG_ORDER, 4'd15);
    write_reg(REG_POST, 4'd1);
    send_item(FUNC_RESTORE, '0, 1'b0, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'h000100, 1'b0, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'h7FFFFF, 1'b1, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'h000001, 1'b0, '0, '0, '0);
    write_reg(REG_ORDER, 4'd8);
    send_item(FUNC_RESTORE, '0, 1'b0, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'hFFFFFF, 1'b0, '0, '0, '0);
    send_item(FUNC_SAMPLE, 24'h000010, 1'b0, '0, '0, '0);
  endtask

  task automatic test_random_phases();
    int s_pct[4] = '{0, 79, 0, 18};
    int r_pct[4] = '{0, 0, 79, 18};
    logic [3:0] ord[4] = '{4'd1, 4'd3, 4'd8, 4'd12};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_ORDER, ord[p]);
      write_reg(REG_POST, 4'(p[0]));
      s_idle_pct = s_pct[p];
      r_stall_pct = r_pct[p];
      repeat (160) send_random();
    end
    s_idle_pct = 0;
    r_stall_pct = 0;
  endtask

  // The receiver holds off while the sender keeps offering beats, so the input must stall.
  task automatic test_backpressure();
    write_reg(REG_ORDER, 4'd2);
    hold_rx = 1;
    repeat (24) send_random();
  endtask

  always begin
    @(posedge clk_i);
    wait (hold_rx);
    repeat (3000) @(posedge clk_i);
    hold_rx = 0;
  end

  always @(negedge clk_i) begin
    out_fire <= m_axis_tvalid && m_axis_tready;
    out_data <= m_axis_tdata;
    out_user <= m_axis_tuser;
  end

  always @(posedge clk_i) begin
    filt_res_t e;
    cycles <= cycles + 1;
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= r_stall_pct);
    if (out_fire) begin
      results_seen++;
      if (out_user[0]) samples_seen++;
      if (out_user[1]) sat_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: data %h user %b", out_data, out_user);
      end else begin
        e = pending.pop_front();
        if (out_data != e.y || out_user[0] != e.is_smp || out_user[1] != e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y %h is_sample %b sat %b, got y %h is_sample %b sat %b",
                     e.y, e.is_smp, e.sat, out_data, out_user[0], out_user[1]);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_iir_direct_form_two_filter_top NOT OK");
      $finish;
    end
  end

  initial begin
    for (int j = 0; j <= MAX_ORD; j++) begin
      b_coef[j] = 0;
      a_coef[j] = 0;
      delays[j] = 0;
      if (j < MAX_ORD) init_vals[j] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk_i);
    $display("checked %0d result beats, %0d filtered samples, %0d clipped", results_seen,
             samples_seen, sat_seen);
    $display("orders 0 to 15, both batch modes, idle and stall phases, one long hold-off");
    if (mismatches == 0 && pending.size() == 0) begin
      $display("tb_iir_direct_form_two_filter_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending.size());
      $display("tb_iir_direct_form_two_filter_top NOT OK");
    end
    $finish;
  end
endmodule
